[src/ckmo_pkg.sv]
package ckmo_pkg;

    localparam int KMER_W = 64;
    localparam int LEN_W  = 6;

    typedef logic [1:0] t_base;

    localparam t_base BASE_MAX = 2'd3;

    typedef enum logic [1:0] {
        ORIENT_FWD = 2'd0,
        ORIENT_RC  = 2'd1,
        ORIENT_PAL = 2'd2
    } t_orient;

    // what one lane reports about its base position
    typedef struct packed {
        t_base fwd;
        t_base rc;
        logic  diff;
        logic  gt;
    } t_lane;

endpackage

[src/ckmo_in_if.sv]
interface ckmo_in_if;
    import ckmo_pkg::*;

    logic              valid;
    logic              ready;
    logic [KMER_W-1:0] kmer_bases;
    logic [LEN_W-1:0]  kmer_length;

    modport source (output valid, output kmer_bases, output kmer_length, input ready);
    modport sink   (input valid, input kmer_bases, input kmer_length, output ready);
endinterface

[src/ckmo_out_if.sv]
interface ckmo_out_if;
    import ckmo_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        orientation;
    logic [KMER_W-1:0] reverse_complement;
    logic [KMER_W-1:0] canonical_bases;

    modport source (output valid, output orientation, output reverse_complement,
                    output canonical_bases, input ready);
    modport sink   (input valid, input orientation, input reverse_complement,
                    input canonical_bases, output ready);
endinterface

[src/ckmo_lane.sv]
module ckmo_lane #(
    parameter int LANE      = 0,
    parameter int NUM_BASES = 32
) (
    input  ckmo_pkg::t_base            i_fwd [NUM_BASES],
    input  logic [ckmo_pkg::LEN_W-1:0] i_len,
    output ckmo_pkg::t_lane            o_lane
);
    import ckmo_pkg::*;

    localparam int IDX_W = (NUM_BASES > 1) ? $clog2(NUM_BASES) : 1;

    logic             active;
    logic [LEN_W-1:0] src;
    t_base            fwd_b;
    t_base            rc_b;

    // mirror position of this lane inside the k-mer
    assign active = i_len > LEN_W'(LANE);
    assign src    = i_len - LEN_W'(LANE) - LEN_W'(1);

    assign fwd_b = active ? i_fwd[LANE] : '0;
    assign rc_b  = active ? t_base'(BASE_MAX - i_fwd[src[IDX_W-1:0]]) : '0;

    assign o_lane.fwd  = fwd_b;
    assign o_lane.rc   = rc_b;
    assign o_lane.diff = fwd_b != rc_b;
    assign o_lane.gt   = fwd_b > rc_b;
endmodule

[src/ckmo_merge.sv]
module ckmo_merge #(
    parameter int NUM_BASES = 32
) (
    input  ckmo_pkg::t_lane             i_lanes [NUM_BASES],
    output ckmo_pkg::t_orient           o_orient,
    output logic [ckmo_pkg::KMER_W-1:0] o_rc,
    output logic [ckmo_pkg::KMER_W-1:0] o_canon
);
    import ckmo_pkg::*;

    logic              found;
    t_orient           orient;
    logic [KMER_W-1:0] fwd_w;
    logic [KMER_W-1:0] rc_w;

    // first differing base, base zero first, decides the order
    always_comb begin
        found  = 1'b0;
        orient = ORIENT_PAL;
        fwd_w  = '0;
        rc_w   = '0;
        for (int i = 0; i < NUM_BASES; i++) begin
            fwd_w[2*i +: 2] = i_lanes[i].fwd;
            rc_w[2*i +: 2]  = i_lanes[i].rc;
            if (!found && i_lanes[i].diff) begin
                found  = 1'b1;
                orient = i_lanes[i].gt ? ORIENT_RC : ORIENT_FWD;
            end
        end
    end

    assign o_orient = orient;
    assign o_rc     = rc_w;
    assign o_canon  = (orient == ORIENT_RC) ? rc_w : fwd_w;
endmodule

[src/canonical_kmer_orientation.sv]
// channel    dir  modport      payload
// i_kmer     in   ckmo_in_if   kmer_bases[63:0], kmer_length[5:0]
// o_result   out  ckmo_out_if  orientation[1:0], reverse_complement[63:0],
//                              canonical_bases[63:0]
//
// one transaction per cycle sustained while o_result.ready stays high
// stages: input register, one lane per base position, priority merge into output register
// each stage holds while the stage after it is full and stalled, so bubbles are squeezed out
// i_rst_n is synchronous and active low; it empties all three stages
module canonical_kmer_orientation #(
    parameter int MAX_BASES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ckmo_in_if.sink    i_kmer,
    ckmo_out_if.source o_result
);
    import ckmo_pkg::*;

    // stage valids and advance enables
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;

    // stage 1: raw bases split per position, length saturated
    t_base            n_s1_bases [MAX_BASES];
    t_base            r_s1_bases [MAX_BASES];
    logic [LEN_W-1:0] n_s1_len;
    logic [LEN_W-1:0] r_s1_len;

    // stage 2: per-lane results
    t_lane n_s2_lanes [MAX_BASES];
    t_lane r_s2_lanes [MAX_BASES];

    // stage 3: output register
    t_orient           n_orient, r_orient;
    logic [KMER_W-1:0] n_rc, r_rc;
    logic [KMER_W-1:0] n_canon, r_canon;

    // a stage can take new data when it is empty or its content moves on
    assign adv3 = !r_v3 || o_result.ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign i_kmer.ready = adv1;

    // lengths above the configured maximum saturate; length zero gives an empty k-mer
    assign n_s1_len = (i_kmer.kmer_length > LEN_W'(MAX_BASES)) ? LEN_W'(MAX_BASES)
                                                               : i_kmer.kmer_length;

    always_comb begin
        for (int i = 0; i < MAX_BASES; i++) begin
            n_s1_bases[i] = i_kmer.kmer_bases[2*i +: 2];
        end
    end

    // one lane for every base position: masked forward base, reverse-complement base,
    // and whether the two strands differ there
    for (genvar g = 0; g < MAX_BASES; g++) begin : g_lane
        ckmo_lane #(
            .LANE      (g),
            .NUM_BASES (MAX_BASES)
        ) u_lane (
            .i_fwd  (r_s1_bases),
            .i_len  (r_s1_len),
            .o_lane (n_s2_lanes[g])
        );
    end

    // merge picks the first position where forward and reverse complement disagree
    ckmo_merge #(
        .NUM_BASES (MAX_BASES)
    ) u_merge (
        .i_lanes  (r_s2_lanes),
        .o_orient (n_orient),
        .o_rc     (n_rc),
        .o_canon  (n_canon)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_kmer.valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // payload registers load only with a valid transaction behind them
    always_ff @(posedge i_clk) begin
        if (adv1 && i_kmer.valid) begin
            r_s1_bases <= n_s1_bases;
            r_s1_len   <= n_s1_len;
        end
        if (adv2 && r_v1) begin
            r_s2_lanes <= n_s2_lanes;
        end
        if (adv3 && r_v2) begin
            r_orient <= n_orient;
            r_rc     <= n_rc;
            r_canon  <= n_canon;
        end
    end

    assign o_result.valid              = r_v3;
    assign o_result.orientation        = r_orient;
    assign o_result.reverse_complement = r_rc;
    assign o_result.canonical_bases    = r_canon;

`ifndef SYNTHESIS
    // reverse complement chosen means it is what the canonical word carries
    a_rc_canon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_orient == ORIENT_RC |-> r_canon == r_rc)
        else $error("canonical bases differ from chosen reverse complement");

    // a palindrome reads the same on both strands
    a_pal_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_orient == ORIENT_PAL |-> r_canon == r_rc)
        else $error("palindromic k-mer with differing strands");

    // an accepted transaction always lands in the first stage
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_kmer.valid && i_kmer.ready |=> r_v1)
        else $error("accepted transaction lost at input stage");

    // a full lane stage never leaves an empty output register behind
    a_out_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !r_v3 |=> r_v3)
        else $error("lane result did not reach the output register");
`endif
endmodule
